>>> src/lrc_pkg.sv
// ----------------------------------------------------------------------------
// lrc_pkg
// Shared types and constants of the LRU reference-count cache table.
// ----------------------------------------------------------------------------
package lrc_pkg;

  // Default table geometry.
  localparam int unsigned EntriesDef = 16;
  localparam int unsigned RefBitsDef = 16;

  // Fixed field widths of the request and response items.
  localparam int unsigned IdW     = 32;
  localparam int unsigned PayW    = 32;
  localparam int unsigned CfgW    = 5;
  localparam int unsigned OutRefW = 16;
  localparam int unsigned OutCntW = 5;

  // Request codes.
  typedef enum logic [2:0] {
    REQ_STORE   = 3'd0,
    REQ_GET     = 3'd1,
    REQ_RELEASE = 3'd2,
    REQ_ADD_REF = 3'd3,
    REQ_FORCE   = 3'd4,
    REQ_PURGE   = 3'd5,
    REQ_TRIM    = 3'd6,
    REQ_PEEK    = 3'd7
  } lrc_req_e;

  // Response status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_PRESENT   = 2'd2,
    ST_FULL      = 2'd3
  } lrc_status_e;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE, S_FIND, S_DECIDE, S_STORE, S_AGE, S_EVICT, S_PROMOTE, S_UPDATE,
    S_CHECK, S_UNTRACK, S_DROP, S_PMARK, S_PFIX, S_TRIM, S_FIN
  } lrc_state_e;

  // Datapath commands.
  typedef enum logic [3:0] {
    CMD_NONE, CMD_START, CMD_FIND, CMD_STORE, CMD_AGE, CMD_EVICT, CMD_PROMOTE,
    CMD_UPDATE, CMD_UNTRACK, CMD_DROP, CMD_PMARK, CMD_PFIX, CMD_TRIM, CMD_FIN
  } lrc_cmd_e;

  // Status from datapath to controller.
  typedef struct packed {
    lrc_req_e req;
    logic     last;
    logic     hit;
    logic     has_free;
    logic     hit_tracked;
    logic     rel_remove;
    logic     max_nz;
    logic     over_limit;
  } lrc_status_t;

endpackage

>>> src/lrc_req_if.sv
// ----------------------------------------------------------------------------
// lrc_req_if
// Request channel: one item is one cache request.
// ----------------------------------------------------------------------------
interface lrc_req_if;
  logic                          valid;
  logic                          ready;
  logic [2:0]                    req_type;
  logic [lrc_pkg::IdW-1:0]       asset_id;
  logic [lrc_pkg::PayW-1:0]      payload_in;

  modport source (output valid, req_type, asset_id, payload_in, input ready);
  modport sink   (input valid, req_type, asset_id, payload_in, output ready);
endinterface

>>> src/lrc_rsp_if.sv
// ----------------------------------------------------------------------------
// lrc_rsp_if
// Response channel: one item is the result of one request.
// ----------------------------------------------------------------------------
interface lrc_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      status;
  logic [lrc_pkg::PayW-1:0]        payload_out;
  logic signed [lrc_pkg::OutRefW-1:0] ref_count;
  logic [lrc_pkg::OutCntW-1:0]     occupancy;
  logic [lrc_pkg::OutCntW-1:0]     removed_count;
  logic                            evicted_valid;
  logic [lrc_pkg::IdW-1:0]         evicted_id;

  modport source (output valid, status, payload_out, ref_count, occupancy,
                  removed_count, evicted_valid, evicted_id, input ready);
  modport sink   (input valid, status, payload_out, ref_count, occupancy,
                  removed_count, evicted_valid, evicted_id, output ready);
endinterface

>>> src/lrc_ctrl.sv
// ----------------------------------------------------------------------------
// lrc_ctrl
// Request sequencer: steps each request through table walks and issues
// datapath commands.
// ----------------------------------------------------------------------------
module lrc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  lrc_pkg::lrc_status_t st_i,
  output lrc_pkg::lrc_cmd_e    cmd_o
);

  lrc_pkg::lrc_state_e state_q, state_d;
  logic                out_valid_q;
  logic                can_fin;

  assign can_fin     = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == lrc_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lrc_pkg::S_IDLE:    if (in_valid_i) state_d = lrc_pkg::S_FIND;
      lrc_pkg::S_FIND:    if (st_i.last) state_d = lrc_pkg::S_DECIDE;
      lrc_pkg::S_DECIDE: begin
        case (st_i.req)
          lrc_pkg::REQ_STORE:
            state_d = (st_i.hit || !st_i.has_free) ? lrc_pkg::S_FIN : lrc_pkg::S_STORE;
          lrc_pkg::REQ_PURGE: state_d = lrc_pkg::S_PMARK;
          lrc_pkg::REQ_TRIM:
            state_d = st_i.over_limit ? lrc_pkg::S_TRIM : lrc_pkg::S_FIN;
          default: begin
            if (!st_i.hit) begin
              state_d = lrc_pkg::S_FIN;
            end else begin
              case (st_i.req)
                lrc_pkg::REQ_GET:
                  state_d = (st_i.max_nz && st_i.hit_tracked) ? lrc_pkg::S_PROMOTE
                                                              : lrc_pkg::S_FIN;
                lrc_pkg::REQ_RELEASE, lrc_pkg::REQ_ADD_REF: state_d = lrc_pkg::S_UPDATE;
                lrc_pkg::REQ_FORCE:
                  state_d = st_i.hit_tracked ? lrc_pkg::S_UNTRACK : lrc_pkg::S_DROP;
                default: state_d = lrc_pkg::S_FIN;
              endcase
            end
          end
        endcase
      end
      lrc_pkg::S_STORE:   state_d = st_i.max_nz ? lrc_pkg::S_AGE : lrc_pkg::S_FIN;
      lrc_pkg::S_AGE:     if (st_i.last) state_d = lrc_pkg::S_EVICT;
      lrc_pkg::S_EVICT:   state_d = lrc_pkg::S_FIN;
      lrc_pkg::S_PROMOTE: if (st_i.last) state_d = lrc_pkg::S_FIN;
      lrc_pkg::S_UPDATE:  state_d = lrc_pkg::S_CHECK;
      lrc_pkg::S_CHECK: begin
        if (st_i.rel_remove) begin
          state_d = st_i.hit_tracked ? lrc_pkg::S_UNTRACK : lrc_pkg::S_DROP;
        end else begin
          state_d = lrc_pkg::S_FIN;
        end
      end
      lrc_pkg::S_UNTRACK: if (st_i.last) state_d = lrc_pkg::S_DROP;
      lrc_pkg::S_DROP:    state_d = lrc_pkg::S_FIN;
      lrc_pkg::S_PMARK:   if (st_i.last) state_d = lrc_pkg::S_PFIX;
      lrc_pkg::S_PFIX:    if (st_i.last) state_d = lrc_pkg::S_FIN;
      lrc_pkg::S_TRIM:    if (st_i.last) state_d = lrc_pkg::S_FIN;
      lrc_pkg::S_FIN:     if (can_fin) state_d = lrc_pkg::S_IDLE;
      default:            state_d = lrc_pkg::S_IDLE;
    endcase
  end

  // Command decode.
  always_comb begin
    cmd_o = lrc_pkg::CMD_NONE;
    unique case (state_q)
      lrc_pkg::S_IDLE:    if (in_valid_i) cmd_o = lrc_pkg::CMD_START;
      lrc_pkg::S_FIND:    cmd_o = lrc_pkg::CMD_FIND;
      lrc_pkg::S_STORE:   cmd_o = lrc_pkg::CMD_STORE;
      lrc_pkg::S_AGE:     cmd_o = lrc_pkg::CMD_AGE;
      lrc_pkg::S_EVICT:   cmd_o = lrc_pkg::CMD_EVICT;
      lrc_pkg::S_PROMOTE: cmd_o = lrc_pkg::CMD_PROMOTE;
      lrc_pkg::S_UPDATE:  cmd_o = lrc_pkg::CMD_UPDATE;
      lrc_pkg::S_UNTRACK: cmd_o = lrc_pkg::CMD_UNTRACK;
      lrc_pkg::S_DROP:    cmd_o = lrc_pkg::CMD_DROP;
      lrc_pkg::S_PMARK:   cmd_o = lrc_pkg::CMD_PMARK;
      lrc_pkg::S_PFIX:    cmd_o = lrc_pkg::CMD_PFIX;
      lrc_pkg::S_TRIM:    cmd_o = lrc_pkg::CMD_TRIM;
      lrc_pkg::S_FIN:     if (can_fin) cmd_o = lrc_pkg::CMD_FIN;
      default:            cmd_o = lrc_pkg::CMD_NONE;
    endcase
  end

  // State and output-valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lrc_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == lrc_pkg::S_FIN && can_fin) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

>>> src/lrc_datapath.sv
// ----------------------------------------------------------------------------
// lrc_datapath
// Entry table, walk counter and result register; executes one command a cycle.
// ----------------------------------------------------------------------------
module lrc_datapath #(
  parameter int unsigned ENTRIES  = lrc_pkg::EntriesDef,
  parameter int unsigned REF_BITS = lrc_pkg::RefBitsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lrc_pkg::lrc_cmd_e                   cmd_i,
  output lrc_pkg::lrc_status_t                st_o,
  input  logic                                cfg_we_i,
  input  logic [lrc_pkg::CfgW-1:0]            cfg_wdata_i,
  input  logic [2:0]                          req_type_i,
  input  logic [lrc_pkg::IdW-1:0]             asset_id_i,
  input  logic [lrc_pkg::PayW-1:0]            payload_in_i,
  output logic [1:0]                          status_o,
  output logic [lrc_pkg::PayW-1:0]            payload_out_o,
  output logic signed [lrc_pkg::OutRefW-1:0]  ref_count_o,
  output logic [lrc_pkg::OutCntW-1:0]         occupancy_o,
  output logic [lrc_pkg::OutCntW-1:0]         removed_count_o,
  output logic                                evicted_valid_o,
  output logic [lrc_pkg::IdW-1:0]             evicted_id_o
);

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(ENTRIES + 1);
  localparam int unsigned CmpW = (CntW > lrc_pkg::CfgW) ? CntW : lrc_pkg::CfgW;
  localparam logic signed [REF_BITS-1:0] RefMax = {1'b0, {(REF_BITS-1){1'b1}}};
  localparam logic signed [REF_BITS-1:0] RefMin = {1'b1, {(REF_BITS-1){1'b0}}};

  // Control state.
  logic [ENTRIES-1:0]          valid_q, tracked_q, gone_q;
  logic [CntW-1:0]             total_q, occ_q, removed_q;
  logic [IdxW-1:0]             idx_q;
  logic [lrc_pkg::CfgW-1:0]    max_q;
  logic                        hit_q, free_q, hit_trk_q, rel_rm_q, tail_vld_q, ev_q;

  // Table contents and per-request captures.
  logic [lrc_pkg::IdW-1:0]     id_q   [ENTRIES];
  logic [lrc_pkg::PayW-1:0]    pay_q  [ENTRIES];
  logic signed [REF_BITS-1:0]  refs_q [ENTRIES];
  logic [IdxW-1:0]             rank_q [ENTRIES];
  lrc_pkg::lrc_req_e           req_q;
  logic [lrc_pkg::IdW-1:0]     rid_q, tail_id_q;
  logic [lrc_pkg::PayW-1:0]    rpay_q, hit_pay_q;
  logic signed [REF_BITS-1:0]  hit_refs_q;
  logic [IdxW-1:0]             hit_idx_q, hit_rank_q, free_idx_q, tail_idx_q;
  logic                        tail_zero_q;

  // Result register.
  logic [1:0]                  res_status_q;
  logic [lrc_pkg::PayW-1:0]    res_pay_q;
  logic signed [REF_BITS-1:0]  res_refs_q;
  logic [CntW-1:0]             res_occ_q, res_removed_q;
  logic                        res_ev_q;
  logic [lrc_pkg::IdW-1:0]     res_evid_q;

  // Current walk entry.
  logic                        cur_valid, cur_tracked, last;
  logic [IdxW-1:0]             cur_rank, gone_below;
  logic signed [REF_BITS-1:0]  cur_refs, upd_refs;
  logic                        id_match, rank_ge_max;
  logic [CntW-1:0]             total_new;
  logic signed [31:0]          res_refs_ext;
  logic [ENTRIES-1:0]          trk_set;
  logic                        evict_drop;

  assign cur_valid   = valid_q[idx_q];
  assign cur_tracked = tracked_q[idx_q];
  assign cur_rank    = rank_q[idx_q];
  assign cur_refs    = refs_q[idx_q];
  assign id_match    = cur_valid && (id_q[idx_q] == rid_q);
  assign last        = (idx_q == IdxW'(ENTRIES - 1));
  assign rank_ge_max = CmpW'(cur_rank) >= CmpW'(max_q);
  assign total_new   = total_q + CntW'(1);

  // Tracking mask with the new entry added, and whether the store drops the tail.
  assign trk_set    = tracked_q | (ENTRIES'(1) << free_idx_q);
  assign evict_drop = (CmpW'(total_new) > CmpW'(max_q)) && tail_vld_q;

  // Number of removed tracked entries ranked ahead of the current one.
  always_comb begin
    gone_below = '0;
    for (int k = 0; k < ENTRIES; k++) begin
      if (gone_q[k] && (IdxW'(k) < cur_rank)) gone_below = gone_below + IdxW'(1);
    end
  end

  // Saturating count update for release and add reference.
  always_comb begin
    upd_refs = hit_refs_q;
    if (req_q == lrc_pkg::REQ_RELEASE) begin
      if (hit_refs_q != RefMin) upd_refs = hit_refs_q - REF_BITS'(1);
    end else if (hit_refs_q != RefMax) begin
      upd_refs = hit_refs_q + REF_BITS'(1);
    end
  end

  // Status toward the controller.
  always_comb begin
    st_o.req         = req_q;
    st_o.last        = last;
    st_o.hit         = hit_q;
    st_o.has_free    = free_q;
    st_o.hit_tracked = hit_trk_q;
    st_o.rel_remove  = rel_rm_q;
    st_o.max_nz      = (max_q != '0);
    st_o.over_limit  = (max_q != '0) && (CmpW'(total_q) > CmpW'(max_q));
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      tracked_q  <= '0;
      gone_q     <= '0;
      total_q    <= '0;
      occ_q      <= '0;
      removed_q  <= '0;
      idx_q      <= '0;
      max_q      <= '0;
      hit_q      <= 1'b0;
      free_q     <= 1'b0;
      hit_trk_q  <= 1'b0;
      rel_rm_q   <= 1'b0;
      tail_vld_q <= 1'b0;
      ev_q       <= 1'b0;
    end else begin
      if (cfg_we_i) max_q <= cfg_wdata_i;
      // Walk commands step the slot counter, which wraps to zero at the end.
      case (cmd_i)
        lrc_pkg::CMD_FIND, lrc_pkg::CMD_AGE, lrc_pkg::CMD_PROMOTE,
        lrc_pkg::CMD_UNTRACK, lrc_pkg::CMD_PMARK, lrc_pkg::CMD_PFIX,
        lrc_pkg::CMD_TRIM: idx_q <= last ? '0 : idx_q + IdxW'(1);
        default: ;
      endcase
      case (cmd_i)
        lrc_pkg::CMD_START: begin
          idx_q      <= '0;
          hit_q      <= 1'b0;
          free_q     <= 1'b0;
          hit_trk_q  <= 1'b0;
          rel_rm_q   <= 1'b0;
          tail_vld_q <= 1'b0;
          ev_q       <= 1'b0;
          gone_q     <= '0;
          removed_q  <= '0;
        end
        lrc_pkg::CMD_FIND: begin
          if (id_match && !hit_q) begin
            hit_q     <= 1'b1;
            hit_trk_q <= cur_tracked;
          end
          if (!cur_valid) free_q <= 1'b1;
        end
        lrc_pkg::CMD_STORE: begin
          valid_q[free_idx_q]   <= 1'b1;
          tracked_q[free_idx_q] <= 1'b0;
          occ_q                 <= occ_q + CntW'(1);
        end
        lrc_pkg::CMD_AGE: begin
          if (cur_tracked && (CntW'(cur_rank) == total_q - CntW'(1))) tail_vld_q <= 1'b1;
        end
        lrc_pkg::CMD_EVICT: begin
          // The new entry joins the order; the old tail leaves it if over the limit.
          if (evict_drop) begin
            tracked_q <= trk_set & ~(ENTRIES'(1) << tail_idx_q);
            if (tail_zero_q) begin
              valid_q[tail_idx_q] <= 1'b0;
              occ_q               <= occ_q - CntW'(1);
              ev_q                <= 1'b1;
            end
          end else begin
            tracked_q <= trk_set;
            total_q   <= total_new;
          end
        end
        lrc_pkg::CMD_UPDATE: begin
          rel_rm_q <= (req_q == lrc_pkg::REQ_RELEASE) && (upd_refs <= 0) && (max_q == '0);
        end
        lrc_pkg::CMD_DROP: begin
          valid_q[hit_idx_q]   <= 1'b0;
          tracked_q[hit_idx_q] <= 1'b0;
          occ_q                <= occ_q - CntW'(1);
          if (hit_trk_q) total_q <= total_q - CntW'(1);
        end
        lrc_pkg::CMD_PMARK: begin
          if (cur_valid && (cur_refs <= 0)) begin
            valid_q[idx_q] <= 1'b0;
            occ_q          <= occ_q - CntW'(1);
            removed_q      <= removed_q + CntW'(1);
            if (cur_tracked) begin
              tracked_q[idx_q]  <= 1'b0;
              gone_q[cur_rank]  <= 1'b1;
              total_q           <= total_q - CntW'(1);
            end
          end
        end
        lrc_pkg::CMD_TRIM: begin
          if (cur_tracked && rank_ge_max) begin
            tracked_q[idx_q] <= 1'b0;
            total_q          <= total_q - CntW'(1);
            if (cur_refs == 0) begin
              valid_q[idx_q] <= 1'b0;
              occ_q          <= occ_q - CntW'(1);
              removed_q      <= removed_q + CntW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Table contents, captures and result register.
  always_ff @(posedge clk_i) begin
    case (cmd_i)
      lrc_pkg::CMD_START: begin
        req_q  <= lrc_pkg::lrc_req_e'(req_type_i);
        rid_q  <= asset_id_i;
        rpay_q <= payload_in_i;
      end
      lrc_pkg::CMD_FIND: begin
        if (id_match && !hit_q) begin
          hit_idx_q  <= idx_q;
          hit_rank_q <= cur_rank;
          hit_pay_q  <= pay_q[idx_q];
          hit_refs_q <= cur_refs;
        end
        if (!cur_valid && !free_q) free_idx_q <= idx_q;
      end
      lrc_pkg::CMD_STORE: begin
        id_q[free_idx_q]   <= rid_q;
        pay_q[free_idx_q]  <= rpay_q;
        refs_q[free_idx_q] <= '0;
      end
      lrc_pkg::CMD_AGE: begin
        if (cur_tracked) begin
          rank_q[idx_q] <= cur_rank + IdxW'(1);
          if (CntW'(cur_rank) == total_q - CntW'(1)) begin
            tail_idx_q  <= idx_q;
            tail_id_q   <= id_q[idx_q];
            tail_zero_q <= (cur_refs == 0);
          end
        end
      end
      lrc_pkg::CMD_EVICT: rank_q[free_idx_q] <= '0;
      lrc_pkg::CMD_PROMOTE: begin
        if (idx_q == hit_idx_q) begin
          rank_q[idx_q] <= '0;
        end else if (cur_tracked && (cur_rank < hit_rank_q)) begin
          rank_q[idx_q] <= cur_rank + IdxW'(1);
        end
      end
      lrc_pkg::CMD_UPDATE: begin
        refs_q[hit_idx_q] <= upd_refs;
        hit_refs_q        <= upd_refs;
      end
      lrc_pkg::CMD_UNTRACK: begin
        if (cur_tracked && (cur_rank > hit_rank_q)) rank_q[idx_q] <= cur_rank - IdxW'(1);
      end
      lrc_pkg::CMD_PFIX: begin
        if (cur_tracked) rank_q[idx_q] <= cur_rank - gone_below;
      end
      lrc_pkg::CMD_FIN: begin
        res_status_q  <= lrc_pkg::ST_OK;
        res_pay_q     <= '0;
        res_refs_q    <= '0;
        res_occ_q     <= occ_q;
        res_removed_q <= '0;
        res_ev_q      <= 1'b0;
        res_evid_q    <= '0;
        case (req_q)
          lrc_pkg::REQ_STORE: begin
            if (hit_q) begin
              res_status_q <= lrc_pkg::ST_PRESENT;
              res_pay_q    <= hit_pay_q;
              res_refs_q   <= hit_refs_q;
            end else if (!free_q) begin
              res_status_q <= lrc_pkg::ST_FULL;
            end else begin
              res_pay_q  <= rpay_q;
              res_ev_q   <= ev_q;
              res_evid_q <= ev_q ? tail_id_q : '0;
            end
          end
          lrc_pkg::REQ_PURGE, lrc_pkg::REQ_TRIM: res_removed_q <= removed_q;
          default: begin
            if (!hit_q) begin
              res_status_q <= lrc_pkg::ST_NOT_FOUND;
            end else begin
              res_pay_q  <= hit_pay_q;
              res_refs_q <= hit_refs_q;
            end
          end
        endcase
      end
      default: ;
    endcase
  end

  assign res_refs_ext    = 32'(res_refs_q);
  assign status_o        = res_status_q;
  assign payload_out_o   = res_pay_q;
  assign ref_count_o     = res_refs_ext[lrc_pkg::OutRefW-1:0];
  assign occupancy_o     = lrc_pkg::OutCntW'(res_occ_q);
  assign removed_count_o = lrc_pkg::OutCntW'(res_removed_q);
  assign evicted_valid_o = res_ev_q;
  assign evicted_id_o    = res_evid_q;

endmodule

>>> src/lru_refcount_cache_table_unit.sv
// ----------------------------------------------------------------------------
// lru_refcount_cache_table_unit
// LRU cache table with reference-count pinning, one result per request.
// ----------------------------------------------------------------------------
// Requests arrive on the req channel (valid/ready); each item carries a
// request type, an asset id and a payload handle. Every request produces
// exactly one item on the rsp channel with status, payload, count,
// occupancy, removed count and eviction report.
// The max_resident register is written through cfg_we_i/cfg_wdata_i; the
// user must do so only while the block is idle (not enforced by the block).
// A lowered limit takes effect on a trim request. Every request first walks
// all table slots, one slot per cycle, to find the id and a free slot.
// Gets of tracked entries and over-limit trims add a second walk, stores
// with LRU enabled an aging walk, a tracked release removal an untracking
// walk, and a purge, the longest, a marking and a fixing walk. One request
// is in flight at a time; the block is ready for the next one once the
// result is registered, even if that result is still waiting. If the
// receiver stalls, the next result is held until the register frees. Reset
// empties the table, clears LRU tracking and sets the limit to zero.
// ----------------------------------------------------------------------------
module lru_refcount_cache_table_unit #(
  parameter int unsigned ENTRIES  = lrc_pkg::EntriesDef,
  parameter int unsigned REF_BITS = lrc_pkg::RefBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  lrc_req_if.sink                     req,
  lrc_rsp_if.source                   rsp,
  input  logic                        cfg_we_i,
  input  logic [lrc_pkg::CfgW-1:0]    cfg_wdata_i
);

  lrc_pkg::lrc_cmd_e    cmd;
  lrc_pkg::lrc_status_t st;

  // Sequencer.
  lrc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req.valid),
    .in_ready_o  (req.ready),
    .out_valid_o (rsp.valid),
    .out_ready_i (rsp.ready),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  // Table and result datapath.
  lrc_datapath #(
    .ENTRIES  (ENTRIES),
    .REF_BITS (REF_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .st_o            (st),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .req_type_i      (req.req_type),
    .asset_id_i      (req.asset_id),
    .payload_in_i    (req.payload_in),
    .status_o        (rsp.status),
    .payload_out_o   (rsp.payload_out),
    .ref_count_o     (rsp.ref_count),
    .occupancy_o     (rsp.occupancy),
    .removed_count_o (rsp.removed_count),
    .evicted_valid_o (rsp.evicted_valid),
    .evicted_id_o    (rsp.evicted_id)
  );

endmodule

>>> verif/lru_refcount_cache_table_unit_tb.sv
// ----------------------------------------------------------------------------
// lru_refcount_cache_table_unit_tb
// Self-checking bench for the LRU reference-count cache table. A driver sends
// request items from a queue with random idle bursts, a monitor checks every
// response item against a behavioral table model, and the LRU limit is
// changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module lru_refcount_cache_table_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumSlots = 16;
  localparam int RefHi = 32767;
  localparam int RefLo = -32768;

  typedef struct packed {
    lrc_pkg::lrc_req_e            kind;
    logic [lrc_pkg::IdW-1:0]      id;
    logic [lrc_pkg::PayW-1:0]     pay;
  } cache_req_t;

  typedef struct packed {
    lrc_pkg::lrc_status_e         status;
    logic [lrc_pkg::PayW-1:0]     pay;
    logic [lrc_pkg::OutRefW-1:0]  refs;
    logic [lrc_pkg::OutCntW-1:0]  occ;
    logic [lrc_pkg::OutCntW-1:0]  removed;
    logic                         ev;
    logic [lrc_pkg::IdW-1:0]      ev_id;
  } cache_rsp_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [lrc_pkg::CfgW-1:0] cfg_wdata_i;

  lrc_req_if req_ch ();
  lrc_rsp_if rsp_ch ();

  lru_refcount_cache_table_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req         (req_ch.sink),
    .rsp         (rsp_ch.source),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Model state of the table.
  bit           m_valid [NumSlots];
  bit [31:0]    m_id [NumSlots];
  bit [31:0]    m_pay [NumSlots];
  int           m_refs [NumSlots];
  bit           m_trk [NumSlots];
  int           m_rank [NumSlots];
  int           m_tracked;
  int           m_limit;

  cache_req_t pending_reqs[$];
  cache_rsp_t expected_rsps[$];
  int  mismatches;
  int  rsp_seen;
  int  evictions_seen;
  bit  quiet;
  bit  req_taken;
  int  idle_left;
  int  stall_left;
  bit [31:0] id_pool [8];

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Time limit.
  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

  function automatic int lookup_slot(bit [31:0] id);
    for (int i = 0; i < NumSlots; i++) begin
      if (m_valid[i] && m_id[i] == id) return i;
    end
    return -1;
  endfunction

  function automatic int resident_total();
    int n;
    n = 0;
    for (int i = 0; i < NumSlots; i++) n += m_valid[i];
    return n;
  endfunction

  // Take a slot out of the LRU order and close the gap.
  function automatic void untrack_slot(int s);
    if (!m_trk[s]) return;
    for (int j = 0; j < NumSlots; j++) begin
      if (m_trk[j] && m_rank[j] > m_rank[s]) m_rank[j]--;
    end
    m_trk[s] = 1'b0;
    if (m_tracked > 0) m_tracked--;
  endfunction

  // Drop the LRU tail; it leaves the table only when it is unpinned.
  function automatic bit drop_lru_tail(output bit [31:0] gone);
    int s;
    s = -1;
    gone = '0;
    if (m_tracked == 0) return 1'b0;
    for (int j = 0; j < NumSlots; j++) begin
      if (m_trk[j] && m_rank[j] == m_tracked - 1) s = j;
    end
    if (s < 0) return 1'b0;
    untrack_slot(s);
    if (m_refs[s] == 0) begin
      m_valid[s] = 1'b0;
      gone = m_id[s];
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Apply one request to the model and return the expected response.
  function automatic cache_rsp_t predict_cache(cache_req_t r);
    cache_rsp_t o;
    int s;
    int refs;
    int removed;
    bit [31:0] gone;
    o = '0;
    refs = 0;
    removed = 0;
    o.status = lrc_pkg::ST_OK;
    s = lookup_slot(r.id);
    case (r.kind)
      lrc_pkg::REQ_STORE: begin
        if (s >= 0) begin
          o.status = lrc_pkg::ST_PRESENT;
          o.pay = m_pay[s];
          refs = m_refs[s];
        end else begin
          for (int i = 0; i < NumSlots && s < 0; i++) begin
            if (!m_valid[i]) s = i;
          end
          if (s < 0) begin
            o.status = lrc_pkg::ST_FULL;
          end else begin
            m_valid[s] = 1'b1;
            m_id[s] = r.id;
            m_pay[s] = r.pay;
            m_refs[s] = 0;
            m_trk[s] = 1'b0;
            o.pay = r.pay;
            if (m_limit > 0) begin
              for (int i = 0; i < NumSlots; i++) begin
                if (m_trk[i]) m_rank[i]++;
              end
              m_trk[s] = 1'b1;
              m_rank[s] = 0;
              m_tracked++;
              if (m_tracked > m_limit && drop_lru_tail(gone)) begin
                o.ev = 1'b1;
                o.ev_id = gone;
              end
            end
          end
        end
      end
      lrc_pkg::REQ_PURGE: begin
        for (int i = 0; i < NumSlots; i++) begin
          if (m_valid[i] && m_refs[i] <= 0) begin
            untrack_slot(i);
            m_valid[i] = 1'b0;
            removed++;
          end
        end
      end
      lrc_pkg::REQ_TRIM: begin
        while (m_limit > 0 && m_tracked > m_limit) removed += drop_lru_tail(gone);
      end
      default: begin
        if (s < 0) begin
          o.status = lrc_pkg::ST_NOT_FOUND;
        end else begin
          o.pay = m_pay[s];
          if (r.kind == lrc_pkg::REQ_GET && m_limit > 0 && m_trk[s]) begin
            for (int i = 0; i < NumSlots; i++) begin
              if (m_trk[i] && m_rank[i] < m_rank[s]) m_rank[i]++;
            end
            m_rank[s] = 0;
          end else if (r.kind == lrc_pkg::REQ_RELEASE) begin
            if (m_refs[s] > RefLo) m_refs[s]--;
          end else if (r.kind == lrc_pkg::REQ_ADD_REF) begin
            if (m_refs[s] < RefHi) m_refs[s]++;
          end
          refs = m_refs[s];
          if (r.kind == lrc_pkg::REQ_FORCE ||
              (r.kind == lrc_pkg::REQ_RELEASE && refs <= 0 && m_limit == 0)) begin
            untrack_slot(s);
            m_valid[s] = 1'b0;
          end
        end
      end
    endcase
    o.refs = refs[15:0];
    o.occ = lrc_pkg::OutCntW'(resident_total());
    o.removed = lrc_pkg::OutCntW'(removed);
    return o;
  endfunction

  // Request acceptance is sampled at the rising edge and fed to the model.
  always @(posedge clk_i) begin
    if (rst_ni && req_ch.valid && req_ch.ready) begin
      expected_rsps.push_back(predict_cache(pending_reqs.pop_front()));
      req_taken = 1'b1;
    end
  end

  // Driver: requests change at the falling edge, with random idle bursts.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!req_ch.valid || req_taken) begin
        req_taken = 1'b0;
        if (idle_left > 0) begin
          idle_left--;
          req_ch.valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
          idle_left = $urandom_range(0, 2);
          req_ch.valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          req_ch.valid      <= 1'b1;
          req_ch.req_type   <= pending_reqs[0].kind;
          req_ch.asset_id   <= pending_reqs[0].id;
          req_ch.payload_in <= pending_reqs[0].pay;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
      // Receiver stalls.
      if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 2);
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Monitor: responses are sampled at the rising edge.
  always @(posedge clk_i) begin
    cache_rsp_t got;
    cache_rsp_t want;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      got.status  = lrc_pkg::lrc_status_e'(rsp_ch.status);
      got.pay     = rsp_ch.payload_out;
      got.refs    = rsp_ch.ref_count;
      got.occ     = rsp_ch.occupancy;
      got.removed = rsp_ch.removed_count;
      got.ev      = rsp_ch.evicted_valid;
      got.ev_id   = rsp_ch.evicted_id;
      rsp_seen++;
      evictions_seen += got.ev;
      if (expected_rsps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response item %p", got);
      end else begin
        want = expected_rsps.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at %0t: expected %p", $time, want);
            $display("                 actual   %p", got);
          end
        end
      end
    end
  end

  function automatic bit [31:0] pick_id();
    return ($urandom_range(0, 15) == 0) ? $urandom() : id_pool[$urandom_range(0, 7)];
  endfunction

  // Queue a burst of random requests over a small id pool.
  task automatic queue_random(int n);
    cache_req_t r;
    for (int k = 0; k < n; k++) begin
      r.id  = pick_id();
      r.pay = $urandom();
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4: r.kind = lrc_pkg::REQ_STORE;
        5, 6, 7:       r.kind = lrc_pkg::REQ_GET;
        8, 9, 10:      r.kind = lrc_pkg::REQ_RELEASE;
        11, 12, 13:    r.kind = lrc_pkg::REQ_ADD_REF;
        14:            r.kind = lrc_pkg::REQ_FORCE;
        15:            r.kind = lrc_pkg::REQ_PURGE;
        16:            r.kind = lrc_pkg::REQ_TRIM;
        default:       r.kind = lrc_pkg::REQ_PEEK;
      endcase
      pending_reqs.push_back(r);
    end
  endtask

  // Wait until every item has been answered, then let the block settle.
  task automatic drain();
    while (pending_reqs.size() > 0 || req_ch.valid || expected_rsps.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (40) @(posedge clk_i);
  endtask

  // Write the limit at a falling edge while the block is idle.
  task automatic set_limit(int value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value[lrc_pkg::CfgW-1:0];
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    m_limit = value;
  endtask

  function automatic void queue_one(lrc_pkg::lrc_req_e kind, bit [31:0] id, bit [31:0] pay);
    cache_req_t r;
    r.kind = kind;
    r.id   = id;
    r.pay  = pay;
    pending_reqs.push_back(r);
  endfunction

  // Stimulus.
  initial begin
    int limits [8];
    req_ch.valid      = 1'b0;
    req_ch.req_type   = '0;
    req_ch.asset_id   = '0;
    req_ch.payload_in = '0;
    rsp_ch.ready      = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_wdata_i       = '0;
    rst_ni            = 1'b0;
    mismatches = 0;
    rsp_seen = 0;
    evictions_seen = 0;
    quiet = 1'b0;
    req_taken = 1'b0;
    idle_left = 0;
    stall_left = 0;
    m_tracked = 0;
    m_limit = 0;
    for (int i = 0; i < NumSlots; i++) begin
      m_valid[i] = 0;
      m_trk[i] = 0;
      m_refs[i] = 0;
      m_rank[i] = 0;
      m_id[i] = 0;
      m_pay[i] = 0;
    end
    id_pool = '{32'h0, 32'hFFFF_FFFF, 32'h1, 32'h8000_0000, 32'h5555_AAAA,
                32'hAAAA_5555, 32'h7, 32'h1234_5678};
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part with the limit at zero: extremes, misses, duplicates,
    // a full table and removal on release.
    queue_one(lrc_pkg::REQ_STORE, 32'h0, 32'hFFFF_FFFF);
    queue_one(lrc_pkg::REQ_STORE, 32'hFFFF_FFFF, 32'h0);
    queue_one(lrc_pkg::REQ_STORE, 32'h0, 32'h1234_5678);
    queue_one(lrc_pkg::REQ_PEEK, 32'hFFFF_FFFF, 32'h0);
    queue_one(lrc_pkg::REQ_GET, 32'hDEAD_BEEF, 32'h0);
    queue_one(lrc_pkg::REQ_ADD_REF, 32'h0, 32'h0);
    queue_one(lrc_pkg::REQ_RELEASE, 32'h0, 32'h0);
    queue_one(lrc_pkg::REQ_RELEASE, 32'hFFFF_FFFF, 32'h0);
    queue_one(lrc_pkg::REQ_FORCE, 32'h0, 32'h0);
    queue_one(lrc_pkg::REQ_FORCE, 32'h0, 32'h0);
    for (int i = 0; i < 17; i++) queue_one(lrc_pkg::REQ_STORE, 32'h100 + i, $urandom());
    queue_one(lrc_pkg::REQ_PURGE, 32'h0, 32'h0);
    queue_one(lrc_pkg::REQ_TRIM, 32'h0, 32'h0);
    drain();

    // Drive one count up, then well below zero with removal on release off.
    queue_one(lrc_pkg::REQ_STORE, 32'h77, 32'h77);
    for (int i = 0; i < 20; i++) queue_one(lrc_pkg::REQ_ADD_REF, 32'h77, 32'h0);
    drain();
    set_limit(16);
    for (int i = 0; i < 44; i++) queue_one(lrc_pkg::REQ_RELEASE, 32'h77, 32'h0);
    queue_one(lrc_pkg::REQ_FORCE, 32'h77, 32'h0);
    queue_one(lrc_pkg::REQ_PURGE, 32'h0, 32'h0);
    drain();

    // Random phases across several limits, each opened by a trim.
    limits = '{1, 3, 16, 0, 2, 31, 8, 1};
    foreach (limits[p]) begin
      set_limit(limits[p]);
      queue_one(lrc_pkg::REQ_TRIM, 32'h0, 32'h0);
      if (p == 7) quiet = 1'b1;
      queue_random(170);
      drain();
    end

    $display("Checked %0d response items over limits 0 to 31, with %0d store evictions.",
             rsp_seen, evictions_seen);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAIL");
    end
    $finish;
  end

endmodule
